@@ sv/cst_pkg.sv @@
// Package for the C subset tokenizer: transfer types, token kind codes and
// the character classification and keyword lookup functions.
// No dependencies.
package cst_pkg;

    localparam int SYMBOL_INDEX_BITS_DEF = 16;
    localparam int LENGTH_BITS_DEF = 16;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_LEVEL_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [5:0] TK_IDENT      = 6'd0;
    localparam logic [5:0] TK_INT        = 6'd1;
    localparam logic [5:0] TK_IF         = 6'd7;
    localparam logic [5:0] TK_ELSE       = 6'd8;
    localparam logic [5:0] TK_DO         = 6'd9;
    localparam logic [5:0] TK_WHILE      = 6'd10;
    localparam logic [5:0] TK_FOR        = 6'd11;
    localparam logic [5:0] TK_BREAK      = 6'd12;
    localparam logic [5:0] TK_CONTINUE   = 6'd13;
    localparam logic [5:0] TK_RETURN     = 6'd14;
    localparam logic [5:0] TK_VOID       = 6'd15;
    localparam logic [5:0] TK_CHAR       = 6'd16;
    localparam logic [5:0] TK_INT_KW     = 6'd17;
    localparam logic [5:0] TK_UNSIGNED   = 6'd18;
    localparam logic [5:0] TK_LONG       = 6'd19;
    localparam logic [5:0] TK_FLOAT      = 6'd20;
    localparam logic [5:0] TK_DOUBLE     = 6'd21;
    localparam logic [5:0] TK_SHORT      = 6'd22;
    localparam logic [5:0] TK_DOT        = 6'd23;
    localparam logic [5:0] TK_BANG       = 6'd24;
    localparam logic [5:0] TK_TILDE      = 6'd25;
    localparam logic [5:0] TK_STAR       = 6'd26;
    localparam logic [5:0] TK_SLASH      = 6'd27;
    localparam logic [5:0] TK_PLUS       = 6'd28;
    localparam logic [5:0] TK_MINUS      = 6'd29;
    localparam logic [5:0] TK_PERCENT    = 6'd30;
    localparam logic [5:0] TK_INCR       = 6'd31;
    localparam logic [5:0] TK_DECR       = 6'd32;
    localparam logic [5:0] TK_ASSIGN     = 6'd33;
    localparam logic [5:0] TK_EQ_EQ      = 6'd34;
    localparam logic [5:0] TK_NOT_EQ     = 6'd35;
    localparam logic [5:0] TK_LESS_EQ    = 6'd36;
    localparam logic [5:0] TK_LESS       = 6'd37;
    localparam logic [5:0] TK_GREATER_EQ = 6'd38;
    localparam logic [5:0] TK_GREATER    = 6'd39;
    localparam logic [5:0] TK_AMP        = 6'd40;
    localparam logic [5:0] TK_AND_AND    = 6'd41;
    localparam logic [5:0] TK_PIPE       = 6'd42;
    localparam logic [5:0] TK_OR_OR      = 6'd43;
    localparam logic [5:0] TK_CARET      = 6'd44;
    localparam logic [5:0] TK_AMP_EQ     = 6'd45;
    localparam logic [5:0] TK_PIPE_EQ    = 6'd46;
    localparam logic [5:0] TK_CARET_EQ   = 6'd47;
    localparam logic [5:0] TK_PLUS_EQ    = 6'd48;
    localparam logic [5:0] TK_MINUS_EQ   = 6'd49;
    localparam logic [5:0] TK_SLASH_EQ   = 6'd50;
    localparam logic [5:0] TK_STAR_EQ    = 6'd51;
    localparam logic [5:0] TK_PERCENT_EQ = 6'd52;
    localparam logic [5:0] TK_LBRACE     = 6'd53;
    localparam logic [5:0] TK_RBRACE     = 6'd54;
    localparam logic [5:0] TK_LPAREN     = 6'd55;
    localparam logic [5:0] TK_RPAREN     = 6'd56;
    localparam logic [5:0] TK_LBRACKET   = 6'd57;
    localparam logic [5:0] TK_RBRACKET   = 6'd58;
    localparam logic [5:0] TK_SEMI       = 6'd59;
    localparam logic [5:0] TK_INVALID    = 6'd60;
    localparam logic [5:0] TK_END        = 6'd61;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } text_item_t;

    typedef struct packed {
        logic [5:0]         token_kind;
        logic [31:0]        token_start;
        logic [15:0]        token_length;
        logic signed [31:0] literal_value;
        logic [15:0]        symbol_index;
        logic               last_of_run;
    } token_t;

    typedef struct packed {
        logic [1:0] count;
        token_t     first;
        token_t     second;
    } push_t;

    function automatic token_t make_token(
        input logic [5:0]  kind,
        input logic [31:0] start,
        input logic [15:0] length,
        input logic [31:0] value,
        input logic [15:0] sym
    );
        token_t t;
        t.token_kind = kind;
        t.token_start = start;
        t.token_length = length;
        t.literal_value = $signed(value);
        t.symbol_index = sym;
        t.last_of_run = 1'b0;
        return t;
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic [5:0] keyword_kind(input logic [63:0] w);
        logic [5:0] k;
        case (w)
            64'h6966:               k = TK_IF;
            64'h656c_7365:          k = TK_ELSE;
            64'h646f:               k = TK_DO;
            64'h77_6869_6c65:       k = TK_WHILE;
            64'h66_6f72:            k = TK_FOR;
            64'h62_7265_616b:       k = TK_BREAK;
            64'h636f_6e74_696e_7565: k = TK_CONTINUE;
            64'h7265_7475_726e:     k = TK_RETURN;
            64'h766f_6964:          k = TK_VOID;
            64'h6368_6172:          k = TK_CHAR;
            64'h69_6e74:            k = TK_INT_KW;
            64'h756e_7369_676e_6564: k = TK_UNSIGNED;
            64'h6c6f_6e67:          k = TK_LONG;
            64'h66_6c6f_6174:       k = TK_FLOAT;
            64'h646f_7562_6c65:     k = TK_DOUBLE;
            64'h73_686f_7274:       k = TK_SHORT;
            default:                k = TK_IDENT;
        endcase
        return k;
    endfunction

    function automatic logic [5:0] single_op_kind(input logic [7:0] c);
        logic [5:0] k;
        case (c)
            "+":     k = TK_PLUS;
            "-":     k = TK_MINUS;
            "/":     k = TK_SLASH;
            "*":     k = TK_STAR;
            "%":     k = TK_PERCENT;
            ">":     k = TK_GREATER;
            "<":     k = TK_LESS;
            "!":     k = TK_BANG;
            "=":     k = TK_ASSIGN;
            "|":     k = TK_PIPE;
            "&":     k = TK_AMP;
            "^":     k = TK_CARET;
            default: k = TK_INVALID;
        endcase
        return k;
    endfunction

    // Returns TK_INVALID when the two characters do not form an operator.
    function automatic logic [5:0] pair_op_kind(input logic [7:0] c, input logic [7:0] d);
        logic [5:0] k;
        k = TK_INVALID;
        if (d == "=")
        begin
            case (c)
                "+":     k = TK_PLUS_EQ;
                "-":     k = TK_MINUS_EQ;
                "/":     k = TK_SLASH_EQ;
                "*":     k = TK_STAR_EQ;
                "%":     k = TK_PERCENT_EQ;
                ">":     k = TK_GREATER_EQ;
                "<":     k = TK_LESS_EQ;
                "!":     k = TK_NOT_EQ;
                "=":     k = TK_EQ_EQ;
                "|":     k = TK_PIPE_EQ;
                "&":     k = TK_AMP_EQ;
                "^":     k = TK_CARET_EQ;
                default: k = TK_INVALID;
            endcase
        end
        else if (c == "+" && d == "+")
        begin
            k = TK_INCR;
        end
        else if (c == "-" && d == "-")
        begin
            k = TK_DECR;
        end
        else if (c == "|" && d == "|")
        begin
            k = TK_OR_OR;
        end
        else if (c == "&" && d == "&")
        begin
            k = TK_AND_AND;
        end
        return k;
    endfunction

    function automatic logic [5:0] punct_kind(input logic [7:0] c);
        logic [5:0] k;
        case (c)
            "{":     k = TK_LBRACE;
            "}":     k = TK_RBRACE;
            "(":     k = TK_LPAREN;
            ")":     k = TK_RPAREN;
            "[":     k = TK_LBRACKET;
            "]":     k = TK_RBRACKET;
            "~":     k = TK_TILDE;
            ".":     k = TK_DOT;
            ";":     k = TK_SEMI;
            default: k = TK_INVALID;
        endcase
        return k;
    endfunction

endpackage

@@ sv/c_subset_tokenizer_top.sv @@
// Top level of the C subset tokenizer: lexer plus result queue.
// Depends on cst_pkg, cst_lexer and cst_token_queue.
//
// Source text enters one byte per transfer on the text channel (text_valid,
// text_stall, text); end_of_text set flushes any pending token and adds an
// End token. Tokens leave one per transfer on the token channel (token_valid,
// token_stall, token); last_of_run marks the final token caused by one byte.
// A byte is lexed combinationally in the cycle it is taken, and its tokens
// are registered in the result queue, which drives the token channel.
// One byte is taken every cycle while the four-entry result queue has room
// for two tokens. A byte that gives two tokens needs two token transfers, so
// a steady stream of such bytes is limited by the single output port of the
// queue.
// Reset clears the lexer to idle between tokens with byte offset zero and
// empties the queue. When the receiver stalls, queued tokens are held and
// text_stall rises as soon as fewer than two queue entries are free.
module c_subset_tokenizer_top #(
    parameter int SYMBOL_INDEX_BITS = cst_pkg::SYMBOL_INDEX_BITS_DEF,
    parameter int LENGTH_BITS = cst_pkg::LENGTH_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                text_valid,
    output logic                text_stall,
    input  cst_pkg::text_item_t text,
    output logic                token_valid,
    input  logic                token_stall,
    output cst_pkg::token_t     token
);

    cst_pkg::push_t                      push;
    logic [cst_pkg::QUEUE_LEVEL_W-1:0]   level;
    logic                                accept;

    assign text_stall = level > cst_pkg::QUEUE_LEVEL_W'(cst_pkg::QUEUE_DEPTH - 2);
    assign accept = text_valid && !text_stall;

    cst_lexer #(
        .SYMBOL_INDEX_BITS(SYMBOL_INDEX_BITS),
        .LENGTH_BITS(LENGTH_BITS)
    ) u_lexer (
        .clk(clk),
        .rst_n(rst_n),
        .accept(accept),
        .text(text),
        .push(push)
    );

    cst_token_queue u_queue (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .token_valid(token_valid),
        .token_stall(token_stall),
        .token(token),
        .level(level)
    );

    assert property (@(posedge clk) disable iff (!rst_n)
        level <= cst_pkg::QUEUE_LEVEL_W'(cst_pkg::QUEUE_DEPTH))
        else $error("result queue overflow");

    assert property (@(posedge clk) disable iff (!rst_n)
        text_valid && !text_stall && text.end_of_text |=> token_valid)
        else $error("end of text transfer produced no token");

    assert property (@(posedge clk) disable iff (!rst_n)
        !accept |-> push.count == 2'd0)
        else $error("tokens pushed without a text transfer");

    assert property (@(posedge clk) disable iff (!rst_n)
        token_valid && token.token_kind == cst_pkg::TK_END |->
            token.token_length == 16'd0 && token.last_of_run)
        else $error("malformed End token");

endmodule

@@ sv/cst_lexer.sv @@
// Lexer state and per-byte token logic: takes one text transfer a cycle and
// produces up to two tokens for the result queue. Depends on cst_pkg.
module cst_lexer #(
    parameter int SYMBOL_INDEX_BITS = cst_pkg::SYMBOL_INDEX_BITS_DEF,
    parameter int LENGTH_BITS = cst_pkg::LENGTH_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  cst_pkg::text_item_t text,
    output cst_pkg::push_t      push
);

    localparam logic [1:0] MODE_IDLE = 2'd0;
    localparam logic [1:0] MODE_IDENT = 2'd1;
    localparam logic [1:0] MODE_NUMBER = 2'd2;
    localparam logic [1:0] MODE_OPER = 2'd3;

    logic [1:0]                   mode_reg, mode_next;
    logic [7:0]                   pending_op_reg, pending_op_next;
    logic [63:0]                  window_reg, window_next;
    logic [31:0]                  start_reg, start_next;
    logic [LENGTH_BITS-1:0]       run_len_reg, run_len_next;
    logic [31:0]                  acc_reg, acc_next;
    logic [31:0]                  pos_reg, pos_next;
    logic [SYMBOL_INDEX_BITS-1:0] id_count_reg, id_count_next;

    logic [7:0]  c;
    logic        c_letter;
    logic        c_digit;
    logic        c_space;
    logic [31:0] run_len_wide;
    logic [31:0] id_count_wide;
    logic [5:0]  ident_kind;
    logic [5:0]  pair_kind;
    logic        a_valid;
    logic        b_valid;
    cst_pkg::token_t a_tok;
    cst_pkg::token_t b_tok;

    assign c = text.text_byte;
    assign c_letter = cst_pkg::is_letter(c);
    assign c_digit = cst_pkg::is_digit(c);
    assign c_space = (c == " ") || (c == "\t") || (c == "\n");
    assign run_len_wide = 32'(run_len_reg);
    assign id_count_wide = 32'(id_count_reg);
    assign ident_kind = (run_len_reg <= LENGTH_BITS'(8)) ?
                        cst_pkg::keyword_kind(window_reg) : cst_pkg::TK_IDENT;
    assign pair_kind = cst_pkg::pair_op_kind(pending_op_reg, c);

    always_comb
    begin
        logic flush;
        logic start_token;

        mode_next = mode_reg;
        pending_op_next = pending_op_reg;
        window_next = window_reg;
        start_next = start_reg;
        run_len_next = run_len_reg;
        acc_next = acc_reg;
        pos_next = pos_reg;
        id_count_next = id_count_reg;
        a_valid = 1'b0;
        b_valid = 1'b0;
        a_tok = cst_pkg::make_token(cst_pkg::TK_INVALID, 32'd0, 16'd0, 32'd0, 16'd0);
        b_tok = a_tok;
        flush = 1'b0;
        start_token = 1'b0;

        if (accept)
        begin
            if (text.end_of_text)
            begin
                flush = 1'b1;
                b_valid = 1'b1;
                b_tok = cst_pkg::make_token(cst_pkg::TK_END, pos_reg, 16'd0, 32'd0, 16'd0);
            end
            else
            begin
                pos_next = pos_reg + 32'd1;
                if (mode_reg == MODE_IDENT && (c_letter || c_digit || c == "_"))
                begin
                    if (run_len_reg < LENGTH_BITS'(8))
                    begin
                        window_next = {window_reg[55:0], c};
                    end
                    if (run_len_reg != '1)
                    begin
                        run_len_next = run_len_reg + LENGTH_BITS'(1);
                    end
                end
                else if (mode_reg == MODE_NUMBER && c_digit)
                begin
                    acc_next = {acc_reg[28:0], 3'b000} + {acc_reg[30:0], 1'b0}
                               + 32'(c[3:0]);
                    if (run_len_reg != '1)
                    begin
                        run_len_next = run_len_reg + LENGTH_BITS'(1);
                    end
                end
                else if (mode_reg == MODE_OPER && pair_kind != cst_pkg::TK_INVALID)
                begin
                    mode_next = MODE_IDLE;
                    a_valid = 1'b1;
                    a_tok = cst_pkg::make_token(pair_kind, start_reg, 16'd2, 32'd0, 16'd0);
                end
                else
                begin
                    flush = 1'b1;
                    start_token = 1'b1;
                end
            end

            if (flush)
            begin
                mode_next = MODE_IDLE;
                case (mode_reg)
                    MODE_IDENT:
                    begin
                        a_valid = 1'b1;
                        if (ident_kind == cst_pkg::TK_IDENT)
                        begin
                            id_count_next = id_count_reg + SYMBOL_INDEX_BITS'(1);
                            a_tok = cst_pkg::make_token(cst_pkg::TK_IDENT, start_reg,
                                                        run_len_wide[15:0], 32'd0,
                                                        id_count_wide[15:0]);
                        end
                        else
                        begin
                            a_tok = cst_pkg::make_token(ident_kind, start_reg,
                                                        run_len_wide[15:0], 32'd0, 16'd0);
                        end
                    end
                    MODE_NUMBER:
                    begin
                        a_valid = 1'b1;
                        a_tok = cst_pkg::make_token(cst_pkg::TK_INT, start_reg,
                                                    run_len_wide[15:0], acc_reg, 16'd0);
                    end
                    MODE_OPER:
                    begin
                        a_valid = 1'b1;
                        a_tok = cst_pkg::make_token(cst_pkg::single_op_kind(pending_op_reg),
                                                    start_reg, 16'd1, 32'd0, 16'd0);
                    end
                    default:
                    begin
                        a_valid = 1'b0;
                    end
                endcase
            end

            if (start_token && !c_space)
            begin
                if (c_letter)
                begin
                    mode_next = MODE_IDENT;
                    start_next = pos_reg;
                    run_len_next = LENGTH_BITS'(1);
                    window_next = 64'(c);
                end
                else if (c >= "1" && c <= "9")
                begin
                    mode_next = MODE_NUMBER;
                    start_next = pos_reg;
                    run_len_next = LENGTH_BITS'(1);
                    acc_next = 32'(c[3:0]);
                end
                else if (c == "0")
                begin
                    b_valid = 1'b1;
                    b_tok = cst_pkg::make_token(cst_pkg::TK_INT, pos_reg, 16'd1, 32'd0, 16'd0);
                end
                else if (cst_pkg::single_op_kind(c) != cst_pkg::TK_INVALID)
                begin
                    mode_next = MODE_OPER;
                    start_next = pos_reg;
                    run_len_next = LENGTH_BITS'(1);
                    pending_op_next = c;
                end
                else
                begin
                    b_valid = 1'b1;
                    b_tok = cst_pkg::make_token(cst_pkg::punct_kind(c), pos_reg, 16'd1,
                                                32'd0, 16'd0);
                end
            end
        end
    end

    always_comb
    begin
        push.count = 2'(a_valid) + 2'(b_valid);
        push.first = a_valid ? a_tok : b_tok;
        push.first.last_of_run = !(a_valid && b_valid);
        push.second = b_tok;
        push.second.last_of_run = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_IDLE;
            pending_op_reg <= 8'd0;
            window_reg <= 64'd0;
            start_reg <= 32'd0;
            run_len_reg <= '0;
            acc_reg <= 32'd0;
            pos_reg <= 32'd0;
            id_count_reg <= '0;
        end
        else
        begin
            mode_reg <= mode_next;
            pending_op_reg <= pending_op_next;
            window_reg <= window_next;
            start_reg <= start_next;
            run_len_reg <= run_len_next;
            acc_reg <= acc_next;
            pos_reg <= pos_next;
            id_count_reg <= id_count_next;
        end
    end

endmodule

@@ sv/cst_token_queue.sv @@
// Result queue for the tokenizer (depends on cst_pkg): takes up to two
// tokens a cycle from the lexer; one token leaves a cycle unless stalled.
module cst_token_queue (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  cst_pkg::push_t                        push,
    output logic                                  token_valid,
    input  logic                                  token_stall,
    output cst_pkg::token_t                       token,
    output logic [cst_pkg::QUEUE_LEVEL_W-1:0]     level
);

    localparam int PW = cst_pkg::QUEUE_PTR_W;
    localparam int LW = cst_pkg::QUEUE_LEVEL_W;

    cst_pkg::token_t entries [cst_pkg::QUEUE_DEPTH];

    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [LW-1:0] level_reg, level_next;
    logic          pop;

    assign token_valid = (level_reg != '0);
    assign token = entries[rd_ptr_reg];
    assign level = level_reg;
    assign pop = token_valid && !token_stall;

    assign wr_ptr_next = wr_ptr_reg + PW'(push.count);
    assign rd_ptr_next = rd_ptr_reg + PW'(pop);
    assign level_next = level_reg + LW'(push.count) - LW'(pop);

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            entries[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            entries[wr_ptr_reg + PW'(1)] <= push.second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg <= level_next;
        end
    end

endmodule

@@ verif/tb_c_subset_tokenizer_top.sv @@
`timescale 1ns / 1ps
// Testbench for c_subset_tokenizer_top. It streams source text through the text channel and
// checks every token against a behavioral lexer that tracks the accepted bytes.
// Depends on cst_pkg and the tokenizer RTL.
module tb_c_subset_tokenizer_top;

    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int DRAIN_LIMIT = 20_000;
    localparam int MAX_PRINTED = 50;
    localparam int GAP_PERCENT = 21;
    localparam logic [15:0] LENGTH_MAX = 16'hFFFF;
    localparam logic [15:0] KEYWORD_MAX = 16'd8;

    typedef enum logic [1:0] {SCAN_IDLE, SCAN_IDENT, SCAN_NUMBER, SCAN_OPER} scan_mode_t;

    logic                clk;
    logic                rst_n;
    logic                text_valid;
    logic                text_stall;
    cst_pkg::text_item_t text;
    logic                token_valid;
    logic                token_stall;
    cst_pkg::token_t     token;

    scan_mode_t  lex_mode;
    logic [7:0]  lex_op;
    logic [63:0] lex_window;
    logic [31:0] lex_start;
    logic [15:0] lex_len;
    logic [31:0] lex_value;
    logic [31:0] lex_pos;
    logic [15:0] lex_ident_count;

    cst_pkg::token_t expected_tokens[$];
    cst_pkg::token_t step_tokens[$];

    int error_count = 0;
    int cycle_count = 0;
    int bytes_sent = 0;
    int tokens_checked = 0;
    int hold_left = 0;
    bit sender_gaps;
    bit receiver_gaps;

    c_subset_tokenizer_top dut (
        .clk(clk),
        .rst_n(rst_n),
        .text_valid(text_valid),
        .text_stall(text_stall),
        .text(text),
        .token_valid(token_valid),
        .token_stall(token_stall),
        .token(token)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic is_num(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic [5:0] lone_op_code(input logic [7:0] c);
        case (c)
            "+": return cst_pkg::TK_PLUS;
            "-": return cst_pkg::TK_MINUS;
            "*": return cst_pkg::TK_STAR;
            "/": return cst_pkg::TK_SLASH;
            "%": return cst_pkg::TK_PERCENT;
            "<": return cst_pkg::TK_LESS;
            ">": return cst_pkg::TK_GREATER;
            "!": return cst_pkg::TK_BANG;
            "=": return cst_pkg::TK_ASSIGN;
            "|": return cst_pkg::TK_PIPE;
            "&": return cst_pkg::TK_AMP;
            "^": return cst_pkg::TK_CARET;
            default: return cst_pkg::TK_INVALID;
        endcase
    endfunction

    function automatic logic [5:0] joined_op_code(input logic [7:0] c, input logic [7:0] d);
        case ({c, d})
            "+=": return cst_pkg::TK_PLUS_EQ;
            "-=": return cst_pkg::TK_MINUS_EQ;
            "*=": return cst_pkg::TK_STAR_EQ;
            "/=": return cst_pkg::TK_SLASH_EQ;
            "%=": return cst_pkg::TK_PERCENT_EQ;
            "<=": return cst_pkg::TK_LESS_EQ;
            ">=": return cst_pkg::TK_GREATER_EQ;
            "!=": return cst_pkg::TK_NOT_EQ;
            "==": return cst_pkg::TK_EQ_EQ;
            "|=": return cst_pkg::TK_PIPE_EQ;
            "&=": return cst_pkg::TK_AMP_EQ;
            "^=": return cst_pkg::TK_CARET_EQ;
            "++": return cst_pkg::TK_INCR;
            "--": return cst_pkg::TK_DECR;
            "||": return cst_pkg::TK_OR_OR;
            "&&": return cst_pkg::TK_AND_AND;
            default: return cst_pkg::TK_INVALID;
        endcase
    endfunction

    function automatic logic [5:0] bracket_code(input logic [7:0] c);
        case (c)
            "{": return cst_pkg::TK_LBRACE;
            "}": return cst_pkg::TK_RBRACE;
            "(": return cst_pkg::TK_LPAREN;
            ")": return cst_pkg::TK_RPAREN;
            "[": return cst_pkg::TK_LBRACKET;
            "]": return cst_pkg::TK_RBRACKET;
            "~": return cst_pkg::TK_TILDE;
            ".": return cst_pkg::TK_DOT;
            ";": return cst_pkg::TK_SEMI;
            default: return cst_pkg::TK_INVALID;
        endcase
    endfunction

    function automatic logic [5:0] keyword_code(input logic [63:0] w);
        case (w)
            "if":       return cst_pkg::TK_IF;
            "else":     return cst_pkg::TK_ELSE;
            "do":       return cst_pkg::TK_DO;
            "while":    return cst_pkg::TK_WHILE;
            "for":      return cst_pkg::TK_FOR;
            "break":    return cst_pkg::TK_BREAK;
            "continue": return cst_pkg::TK_CONTINUE;
            "return":   return cst_pkg::TK_RETURN;
            "void":     return cst_pkg::TK_VOID;
            "char":     return cst_pkg::TK_CHAR;
            "int":      return cst_pkg::TK_INT_KW;
            "unsigned": return cst_pkg::TK_UNSIGNED;
            "long":     return cst_pkg::TK_LONG;
            "float":    return cst_pkg::TK_FLOAT;
            "double":   return cst_pkg::TK_DOUBLE;
            "short":    return cst_pkg::TK_SHORT;
            default:    return cst_pkg::TK_IDENT;
        endcase
    endfunction

    function automatic string keyword_text(input int i);
        case (i)
            0:  return "if";
            1:  return "else";
            2:  return "do";
            3:  return "while";
            4:  return "for";
            5:  return "break";
            6:  return "continue";
            7:  return "return";
            8:  return "void";
            9:  return "char";
            10: return "int";
            11: return "unsigned";
            12: return "long";
            13: return "float";
            14: return "double";
            default: return "short";
        endcase
    endfunction

    function automatic void add_token(input logic [5:0] kind, input logic [31:0] start,
                                      input logic [15:0] len, input logic [31:0] value,
                                      input logic [15:0] sym);
        cst_pkg::token_t t;
        t.token_kind = kind;
        t.token_start = start;
        t.token_length = len;
        t.literal_value = value;
        t.symbol_index = sym;
        t.last_of_run = 1'b0;
        step_tokens.push_back(t);
    endfunction

    function automatic void close_token();
        logic [5:0]  kind;
        logic [15:0] sym;
        sym = '0;
        case (lex_mode)
            SCAN_IDENT:
            begin
                kind = (lex_len <= KEYWORD_MAX) ? keyword_code(lex_window)
                                                : cst_pkg::TK_IDENT;
                if (kind == cst_pkg::TK_IDENT)
                begin
                    sym = lex_ident_count;
                    lex_ident_count = lex_ident_count + 16'd1;
                end
                add_token(kind, lex_start, lex_len, '0, sym);
            end
            SCAN_NUMBER: add_token(cst_pkg::TK_INT, lex_start, lex_len, lex_value, '0);
            SCAN_OPER:   add_token(lone_op_code(lex_op), lex_start, 16'd1, '0, '0);
            default:     ;
        endcase
        lex_mode = SCAN_IDLE;
    endfunction

    function automatic void open_token(input logic [7:0] c, input logic [31:0] pos);
        if (c == " " || c == "\t" || c == "\n")
            return;
        if (is_alpha(c))
        begin
            lex_mode = SCAN_IDENT;
            lex_start = pos;
            lex_len = 16'd1;
            lex_window = {56'd0, c};
        end
        else if (c >= "1" && c <= "9")
        begin
            lex_mode = SCAN_NUMBER;
            lex_start = pos;
            lex_len = 16'd1;
            lex_value = {24'd0, c} - 32'd48;
        end
        else if (c == "0")
            add_token(cst_pkg::TK_INT, pos, 16'd1, '0, '0);
        else if (lone_op_code(c) != cst_pkg::TK_INVALID)
        begin
            lex_mode = SCAN_OPER;
            lex_start = pos;
            lex_len = 16'd1;
            lex_op = c;
        end
        else
            add_token(bracket_code(c), pos, 16'd1, '0, '0);
    endfunction

    // Works out the tokens that one accepted text transfer causes.
    function automatic void lex_predict(input logic [7:0] c, input logic eot);
        logic [31:0]     pos;
        logic [5:0]      pair;
        logic            absorbed;
        cst_pkg::token_t t;
        int              n;
        absorbed = 1'b0;
        if (eot)
        begin
            close_token();
            add_token(cst_pkg::TK_END, lex_pos, '0, '0, '0);
        end
        else
        begin
            pos = lex_pos;
            lex_pos = lex_pos + 32'd1;
            case (lex_mode)
                SCAN_IDENT:
                    if (is_alpha(c) || is_num(c) || c == "_")
                    begin
                        if (lex_len < KEYWORD_MAX)
                            lex_window = {lex_window[55:0], c};
                        if (lex_len != LENGTH_MAX)
                            lex_len = lex_len + 16'd1;
                        absorbed = 1'b1;
                    end
                SCAN_NUMBER:
                    if (is_num(c))
                    begin
                        lex_value = lex_value * 32'd10 + ({24'd0, c} - 32'd48);
                        if (lex_len != LENGTH_MAX)
                            lex_len = lex_len + 16'd1;
                        absorbed = 1'b1;
                    end
                SCAN_OPER:
                begin
                    pair = joined_op_code(lex_op, c);
                    if (pair != cst_pkg::TK_INVALID)
                    begin
                        lex_mode = SCAN_IDLE;
                        add_token(pair, lex_start, 16'd2, '0, '0);
                        absorbed = 1'b1;
                    end
                end
                default: ;
            endcase
            if (!absorbed)
            begin
                close_token();
                open_token(c, pos);
            end
        end
        n = step_tokens.size();
        for (int i = 0; i < n; i++)
        begin
            t = step_tokens[i];
            t.last_of_run = (i == n - 1);
            expected_tokens.push_back(t);
        end
        step_tokens.delete();
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (error_count < MAX_PRINTED)
            $display("%0t: %s: got %0h, expected %0h", $time, what, got, want);
        error_count++;
    endtask

    // Called and returns at a falling edge; valid stays high into the next call.
    task automatic send_text(input logic [7:0] c, input logic eot);
        while (sender_gaps && $urandom_range(0, 99) < GAP_PERCENT)
        begin
            text_valid <= 1'b0;
            @(negedge clk);
        end
        text_valid <= 1'b1;
        text <= {c, eot};
        @(posedge clk);
        while (text_stall)
            @(posedge clk);
        lex_predict(c, eot);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic send_string(input string s);
        for (int i = 0; i < s.len(); i++)
            send_text(s[i], 1'b0);
    endtask

    task automatic wait_drained();
        int waited;
        waited = 0;
        text_valid <= 1'b0;
        while (expected_tokens.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(negedge clk);
            waited++;
        end
        if (expected_tokens.size() != 0)
        begin
            report_mismatch("tokens never delivered", expected_tokens.size(), 0);
            expected_tokens.delete();
        end
        @(negedge clk);
    endtask

    function automatic logic [7:0] random_letter();
        logic [7:0] c;
        if ($urandom_range(0, 1))
            c = $urandom_range("a", "z");
        else
            c = $urandom_range("A", "Z");
        return c;
    endfunction

    function automatic logic [7:0] random_name_char();
        logic [7:0] c;
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 6)
            c = random_letter();
        else if (pick < 9)
            c = $urandom_range("0", "9");
        else
            c = "_";
        return c;
    endfunction

    task automatic send_random_token();
        int    pick;
        int    n;
        string word;
        pick = $urandom_range(0, 99);
        if (pick < 14)
            send_string(keyword_text($urandom_range(0, 15)));
        else if (pick < 22)
        begin
            word = keyword_text($urandom_range(0, 15));
            n = $urandom_range(1, word.len());
            for (int i = 0; i < n; i++)
                send_text(word[i], 1'b0);
            if ($urandom_range(0, 1))
                send_text(random_name_char(), 1'b0);
        end
        else if (pick < 38)
        begin
            send_text(random_letter(), 1'b0);
            repeat ($urandom_range(0, 10))
                send_text(random_name_char(), 1'b0);
        end
        else if (pick < 54)
        begin
            if ($urandom_range(0, 9) == 0)
                send_text("0", 1'b0);
            else
            begin
                send_text($urandom_range("1", "9"), 1'b0);
                repeat ($urandom_range(0, 11))
                    send_text($urandom_range("0", "9"), 1'b0);
            end
        end
        else if (pick < 64)
        begin
            word = "+-*/%<>!=|&^";
            send_text(word[$urandom_range(0, word.len() - 1)], 1'b0);
        end
        else if (pick < 74)
        begin
            word = "++--||&&+=-=*=/=%=<=>=!===|=&=^=";
            n = 2 * $urandom_range(0, word.len() / 2 - 1);
            send_text(word[n], 1'b0);
            send_text(word[n + 1], 1'b0);
        end
        else if (pick < 85)
        begin
            word = "{}()[]~.;";
            send_text(word[$urandom_range(0, word.len() - 1)], 1'b0);
        end
        else if (pick < 96)
            send_text($urandom_range(0, 255), 1'b0);
        else
            send_text($urandom_range(0, 255), 1'b1);
        if ($urandom_range(0, 99) < 55)
        begin
            word = " \t\n";
            send_text(word[$urandom_range(0, 2)], 1'b0);
        end
    endtask

    task automatic test_directed_text();
        send_string("while(x_1<=099)");
        send_text(8'h00, 1'b0);
        send_text(8'h0D, 1'b0);
        send_text("_", 1'b0);
        send_text(8'hFF, 1'b0);
        send_text("\t", 1'b0);
        send_text(8'hA5, 1'b1);
        send_text(8'h5A, 1'b1);
        send_string("Zq9 ");
        wait_drained();
    endtask

    task automatic test_random_source();
        int first;
        first = bytes_sent;
        while (bytes_sent - first < 480)
        begin
            sender_gaps = (bytes_sent - first < 300);
            receiver_gaps = sender_gaps;
            send_random_token();
        end
        send_text(8'h00, 1'b1);
        wait_drained();
        sender_gaps = 1'b1;
        receiver_gaps = 1'b1;
    endtask

    task automatic test_receiver_hold();
        hold_left = 300;
        repeat (40)
            send_string("a(");
        wait_drained();
    endtask

    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            token_stall <= 1'b1;
            hold_left = hold_left - 1;
        end
        else
            token_stall <= receiver_gaps && ($urandom_range(0, 99) < GAP_PERCENT);
    end

    always @(posedge clk)
    begin : check_tokens
        cst_pkg::token_t want;
        if (rst_n && token_valid && !token_stall)
        begin
            if (expected_tokens.size() == 0)
                report_mismatch("token with none expected", token.token_kind, 0);
            else
            begin
                want = expected_tokens.pop_front();
                tokens_checked++;
                if (token.token_kind !== want.token_kind)
                    report_mismatch("token_kind", token.token_kind, want.token_kind);
                if (token.token_start !== want.token_start)
                    report_mismatch("token_start", token.token_start, want.token_start);
                if (token.token_length !== want.token_length)
                    report_mismatch("token_length", token.token_length, want.token_length);
                if (token.literal_value !== want.literal_value)
                    report_mismatch("literal_value", token.literal_value, want.literal_value);
                if (token.symbol_index !== want.symbol_index)
                    report_mismatch("symbol_index", token.symbol_index, want.symbol_index);
                if (token.last_of_run !== want.last_of_run)
                    report_mismatch("last_of_run", token.last_of_run, want.last_of_run);
            end
        end
    end

    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Timed out after %0d cycles.", cycle_count);
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        text_valid = 1'b0;
        text = '0;
        sender_gaps = 1'b1;
        receiver_gaps = 1'b1;
        lex_mode = SCAN_IDLE;
        lex_op = '0;
        lex_window = '0;
        lex_start = '0;
        lex_len = '0;
        lex_value = '0;
        lex_pos = '0;
        lex_ident_count = '0;
        repeat (3)
            @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed_text();
        test_random_source();
        test_receiver_hold();

        wait_drained();
        repeat (8)
            @(negedge clk);
        $display("Sent %0d text bytes and checked %0d tokens across keywords, identifiers,",
                 bytes_sent, tokens_checked);
        $display("literals, operators, invalid bytes, end flags and a receiver hold-off.");
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
